// File: hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros used by the checker file of the execute block.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, reset included.
`define E8_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked on every rising edge of clk outside reset.
`define E8_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: hdl/e8_pkg.sv
// -----------------------------------------------------------------------------
// e8_pkg
// Types and constants for the 8-bit CPU execute block.
// -----------------------------------------------------------------------------
package e8_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_TRAP    = 2'd1,
    ST_HALTED  = 2'd2
  } status_t;

  // Register pair selected by opcode bits 5:4.
  typedef enum logic [1:0] {
    PAIR_BC = 2'd0,
    PAIR_DE = 2'd1,
    PAIR_HL = 2'd2,
    PAIR_SP = 2'd3
  } pair_t;

  // Instruction classes after decode.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LXI,
    OP_STAX,
    OP_INX,
    OP_INR,
    OP_DCR,
    OP_MVI,
    OP_RLC,
    OP_DAD,
    OP_TRAP
  } op_kind_t;

  // Supported opcodes.
  localparam logic [7:0] OPC_NOP     = 8'h00;
  localparam logic [7:0] OPC_LXI_B   = 8'h01;
  localparam logic [7:0] OPC_STAX_B  = 8'h02;
  localparam logic [7:0] OPC_INX_B   = 8'h03;
  localparam logic [7:0] OPC_INR_B   = 8'h04;
  localparam logic [7:0] OPC_DCR_B   = 8'h05;
  localparam logic [7:0] OPC_MVI_B   = 8'h06;
  localparam logic [7:0] OPC_RLC     = 8'h07;
  localparam logic [7:0] OPC_DAD_B   = 8'h09;
  localparam logic [7:0] OPC_LXI_D   = 8'h11;
  localparam logic [7:0] OPC_STAX_D  = 8'h12;
  localparam logic [7:0] OPC_INX_D   = 8'h13;
  localparam logic [7:0] OPC_DAD_D   = 8'h19;
  localparam logic [7:0] OPC_LXI_H   = 8'h21;
  localparam logic [7:0] OPC_INX_H   = 8'h23;
  localparam logic [7:0] OPC_DAD_H   = 8'h29;
  localparam logic [7:0] OPC_LXI_SP  = 8'h31;
  localparam logic [7:0] OPC_INX_SP  = 8'h33;

  // Undocumented opcodes that behave as NOP.
  localparam logic [7:0] OPC_ALT_NOP_08 = 8'h08;
  localparam logic [7:0] OPC_ALT_NOP_10 = 8'h10;
  localparam logic [7:0] OPC_ALT_NOP_18 = 8'h18;
  localparam logic [7:0] OPC_ALT_NOP_20 = 8'h20;
  localparam logic [7:0] OPC_ALT_NOP_28 = 8'h28;
  localparam logic [7:0] OPC_ALT_NOP_30 = 8'h30;
  localparam logic [7:0] OPC_ALT_NOP_38 = 8'h38;
  localparam logic [7:0] OPC_ALT_NOP_CB = 8'hcb;
  localparam logic [7:0] OPC_ALT_NOP_D9 = 8'hd9;
  localparam logic [7:0] OPC_ALT_NOP_DD = 8'hdd;
  localparam logic [7:0] OPC_ALT_NOP_ED = 8'hed;
  localparam logic [7:0] OPC_ALT_NOP_FD = 8'hfd;

  // Bit positions in the flag word.
  localparam int FLAG_CY = 0;
  localparam int FLAG_P  = 1;
  localparam int FLAG_AC = 2;
  localparam int FLAG_Z  = 3;
  localparam int FLAG_S  = 4;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
  } instr_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] next_pc;
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  acc;
    logic [4:0]  flag_bits;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [15:0] stack_pointer;
  } result_t;

  // Decoded control for one instruction.
  typedef struct packed {
    op_kind_t   kind;
    pair_t      pair;
    logic [1:0] adv;
  } ctrl_t;

endpackage

// File: hdl/e8_stream_if.sv
// -----------------------------------------------------------------------------
// e8_stream_if
// Valid/ready channel carrying one word of a given payload type.
// -----------------------------------------------------------------------------
interface e8_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/e8_decode.sv
// -----------------------------------------------------------------------------
// e8_decode
// Opcode decoder: instruction class, register pair and PC advance.
// -----------------------------------------------------------------------------
module e8_decode (
  input  logic [7:0]    opcode,
  output e8_pkg::ctrl_t ctrl
);

  always_comb begin
    ctrl.pair = e8_pkg::pair_t'(opcode[5:4]);
    ctrl.adv  = 2'd1;
    unique case (opcode) inside
      e8_pkg::OPC_NOP,
      e8_pkg::OPC_ALT_NOP_08, e8_pkg::OPC_ALT_NOP_10, e8_pkg::OPC_ALT_NOP_18,
      e8_pkg::OPC_ALT_NOP_20, e8_pkg::OPC_ALT_NOP_28, e8_pkg::OPC_ALT_NOP_30,
      e8_pkg::OPC_ALT_NOP_38, e8_pkg::OPC_ALT_NOP_CB, e8_pkg::OPC_ALT_NOP_D9,
      e8_pkg::OPC_ALT_NOP_DD, e8_pkg::OPC_ALT_NOP_ED,
      e8_pkg::OPC_ALT_NOP_FD: begin
        ctrl.kind = e8_pkg::OP_NOP;
      end
      e8_pkg::OPC_LXI_B, e8_pkg::OPC_LXI_D, e8_pkg::OPC_LXI_H,
      e8_pkg::OPC_LXI_SP: begin
        ctrl.kind = e8_pkg::OP_LXI;
        ctrl.adv  = 2'd3;
      end
      e8_pkg::OPC_STAX_B, e8_pkg::OPC_STAX_D: begin
        ctrl.kind = e8_pkg::OP_STAX;
      end
      e8_pkg::OPC_INX_B, e8_pkg::OPC_INX_D, e8_pkg::OPC_INX_H,
      e8_pkg::OPC_INX_SP: begin
        ctrl.kind = e8_pkg::OP_INX;
      end
      e8_pkg::OPC_INR_B: begin
        ctrl.kind = e8_pkg::OP_INR;
      end
      e8_pkg::OPC_DCR_B: begin
        ctrl.kind = e8_pkg::OP_DCR;
      end
      e8_pkg::OPC_MVI_B: begin
        ctrl.kind = e8_pkg::OP_MVI;
        ctrl.adv  = 2'd2;
      end
      e8_pkg::OPC_RLC: begin
        ctrl.kind = e8_pkg::OP_RLC;
      end
      e8_pkg::OPC_DAD_B, e8_pkg::OPC_DAD_D, e8_pkg::OPC_DAD_H: begin
        ctrl.kind = e8_pkg::OP_DAD;
      end
      default: begin
        // Everything else, DAD SP included, stops the processor.
        ctrl.kind = e8_pkg::OP_TRAP;
        ctrl.adv  = 2'd0;
      end
    endcase
  end

endmodule

// File: hdl/e8_core.sv
// -----------------------------------------------------------------------------
// e8_core
// Architectural registers and the combinational execute datapath.
// -----------------------------------------------------------------------------
module e8_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  e8_pkg::instr_t   instr,
  input  e8_pkg::ctrl_t    ctrl,
  output e8_pkg::result_t  result
);

  logic [7:0]  a, b, c, d, e, h, l;
  logic [15:0] sp, pc;
  logic [4:0]  flags;
  logic        halted;

  logic [7:0]  a_next, b_next, c_next, d_next, e_next, h_next, l_next;
  logic [15:0] sp_next, pc_next;
  logic [4:0]  flags_next;
  logic        halted_next;

  logic [15:0]     sel_pair;
  logic [15:0]     pair_wdata;
  logic            pair_we;
  e8_pkg::pair_t   pair_dst;
  logic [16:0]     dad_sum;
  logic [7:0]      b_alu;
  logic [1:0]      adv;
  e8_pkg::status_t status;
  logic            wv;
  logic [15:0]     waddr;
  logic [7:0]      wdata;

  always_comb begin
    case (ctrl.pair)
      e8_pkg::PAIR_BC: sel_pair = {b, c};
      e8_pkg::PAIR_DE: sel_pair = {d, e};
      e8_pkg::PAIR_HL: sel_pair = {h, l};
      default:         sel_pair = sp;
    endcase
  end

  assign dad_sum = {1'b0, h, l} + {1'b0, sel_pair};

  always_comb begin
    a_next      = a;
    b_alu       = b;
    flags_next  = flags;
    halted_next = halted;
    pair_we     = 1'b0;
    pair_dst    = ctrl.pair;
    pair_wdata  = sel_pair;
    status      = e8_pkg::ST_EXEC;
    adv         = 2'd0;
    wv          = 1'b0;
    waddr       = 16'h0000;
    wdata       = 8'h00;

    if (halted) begin
      status = e8_pkg::ST_HALTED;
    end else begin
      adv = ctrl.adv;
      unique case (ctrl.kind)
        e8_pkg::OP_NOP: begin
        end
        e8_pkg::OP_LXI: begin
          pair_we    = 1'b1;
          pair_wdata = {instr.operand_high, instr.operand_low};
        end
        e8_pkg::OP_STAX: begin
          wv    = 1'b1;
          waddr = sel_pair;
          wdata = a;
        end
        e8_pkg::OP_INX: begin
          pair_we    = 1'b1;
          pair_wdata = sel_pair + 16'd1;
        end
        e8_pkg::OP_INR, e8_pkg::OP_DCR: begin
          if (ctrl.kind == e8_pkg::OP_INR) begin
            b_alu = b + 8'd1;
            flags_next[e8_pkg::FLAG_AC] = (b[3:0] == 4'hf);
          end else begin
            b_alu = b - 8'd1;
            // Auxiliary carry is set when the low nibble does not borrow.
            flags_next[e8_pkg::FLAG_AC] = (b[3:0] != 4'h0);
          end
          flags_next[e8_pkg::FLAG_Z] = (b_alu == 8'h00);
          flags_next[e8_pkg::FLAG_S] = b_alu[7];
          flags_next[e8_pkg::FLAG_P] = ~^b_alu;
        end
        e8_pkg::OP_MVI: begin
          b_alu = instr.operand_low;
        end
        e8_pkg::OP_RLC: begin
          a_next = {a[6:0], a[7]};
          flags_next[e8_pkg::FLAG_CY] = a[7];
        end
        e8_pkg::OP_DAD: begin
          pair_we    = 1'b1;
          pair_dst   = e8_pkg::PAIR_HL;
          pair_wdata = dad_sum[15:0];
          flags_next[e8_pkg::FLAG_CY] = dad_sum[16];
        end
        default: begin
          status      = e8_pkg::ST_TRAP;
          halted_next = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    b_next  = b_alu;
    c_next  = c;
    d_next  = d;
    e_next  = e;
    h_next  = h;
    l_next  = l;
    sp_next = sp;
    if (pair_we) begin
      case (pair_dst)
        e8_pkg::PAIR_BC: {b_next, c_next} = pair_wdata;
        e8_pkg::PAIR_DE: {d_next, e_next} = pair_wdata;
        e8_pkg::PAIR_HL: {h_next, l_next} = pair_wdata;
        default:         sp_next = pair_wdata;
      endcase
    end
  end

  assign pc_next = pc + {14'd0, adv};

  always_ff @(posedge clk) begin
    if (rst) begin
      a      <= 8'h00;
      b      <= 8'h00;
      c      <= 8'h00;
      d      <= 8'h00;
      e      <= 8'h00;
      h      <= 8'h00;
      l      <= 8'h00;
      sp     <= 16'h0000;
      pc     <= 16'h0000;
      flags  <= 5'h00;
      halted <= 1'b0;
    end else if (step) begin
      a      <= a_next;
      b      <= b_next;
      c      <= c_next;
      d      <= d_next;
      e      <= e_next;
      h      <= h_next;
      l      <= l_next;
      sp     <= sp_next;
      pc     <= pc_next;
      flags  <= flags_next;
      halted <= halted_next;
    end
  end

  always_comb begin
    result.status        = status;
    result.next_pc       = pc_next;
    result.write_valid   = wv;
    result.write_address = waddr;
    result.write_data    = wdata;
    result.acc           = a_next;
    result.flag_bits     = flags_next;
    result.pair_bc       = {b_next, c_next};
    result.pair_de       = {d_next, e_next};
    result.pair_hl       = {h_next, l_next};
    result.stack_pointer = sp_next;
  end

endmodule

// File: hdl/eight_bit_cpu_execute_subset.sv
// -----------------------------------------------------------------------------
// eight_bit_cpu_execute_subset
// Executes one instruction of a subset of the classic 8-bit CPU per word.
// -----------------------------------------------------------------------------
// An accepted word waits in the instruction register; when the core steps,
// its result word goes to the result register. Throughput: one instruction
// per cycle unless the result is stalled; registers and flags update in the
// same cycle as the result register, so the next word can follow directly.
// Sync active-high reset clears registers, flags, PC, halt flag, both stages.
module eight_bit_cpu_execute_subset (
  input  logic       clk,
  input  logic       rst,
  e8_stream_if.sink   instr,
  e8_stream_if.source result
);

  e8_pkg::instr_t  instr_q;
  logic            instr_q_valid;
  e8_pkg::ctrl_t   ctrl;
  e8_pkg::result_t core_result;
  e8_pkg::result_t result_q;
  logic            result_q_valid;
  logic            out_free;
  logic            step;

  assign out_free    = !result_q_valid || result.ready;
  assign instr.ready = !instr_q_valid || out_free;
  assign step        = instr_q_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      instr_q_valid <= 1'b0;
    end else if (instr.ready) begin
      instr_q_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.ready && instr.valid) begin
      instr_q <= instr.payload;
    end
  end

  e8_decode u_decode (
    .opcode (instr_q.opcode),
    .ctrl   (ctrl)
  );

  e8_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .instr  (instr_q),
    .ctrl   (ctrl),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_q_valid <= 1'b0;
    end else if (out_free) begin
      result_q_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= core_result;
    end
  end

  assign result.valid   = result_q_valid;
  assign result.payload = result_q;

endmodule

// File: hdl/e8_checker.sv
// -----------------------------------------------------------------------------
// e8_checker
// Port-level assertions for the execute block, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module e8_checker (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_ready,
  input e8_pkg::result_t res
);

  // A stalled result word must not change.
  `E8_ASSERT_RUN(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res), "result changed while stalled")

  // Nothing is offered in the cycle after reset.
  `E8_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid straight after reset")

  // A trapped or halted instruction never stores to memory.
  `E8_ASSERT_RUN(a_no_store_stopped, res_valid && res.status != e8_pkg::ST_EXEC |-> !res.write_valid && res.write_address == 16'h0000 && res.write_data == 8'h00, "store issued while stopped")

  // A store writes the accumulator, which the store itself leaves unchanged.
  `E8_ASSERT_RUN(a_store_data, res_valid && res.write_valid |-> res.write_data == res.acc && res.status == e8_pkg::ST_EXEC, "store data differs from accumulator")

endmodule

bind eight_bit_cpu_execute_subset e8_checker u_e8_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res       (result.payload)
);
